// File: hw/rtl/first_fit_block_allocator_core_macros.svh
// ---------------------------------------------------------------------------
// First-fit allocator assertion macros
// Shared assertion forms for the allocator checker.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: hw/rtl/ffba_pkg.sv
// ---------------------------------------------------------------------------
// First-fit allocator package
// Default sizes, opcodes and status codes.
// ---------------------------------------------------------------------------
package ffba_pkg;

    localparam int ARENA_BYTES_DEF  = 8192;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_BLOCKS_DEF   = 64;

    localparam int FIELD_W = 13;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

endpackage

// File: hw/rtl/first_fit_block_allocator_core.sv
// Operation: a request walks the table entry by entry; a split shifts entries up, a free adds
// its merge scan and shifts entries down; a response still held stalls the next one.
// Throughput: one request at a time; the table walk sets the rate.
// Reset: asynchronous, active low; after reset the INIT state writes the initial free block,
// during which no request is taken.
// ---------------------------------------------------------------------------
// First-fit block allocator core
// Address-ordered block table in one synchronous memory, walked one entry
// per cycle; splits and merges shift entries through the same memory.
// ---------------------------------------------------------------------------
module first_fit_block_allocator_core #(
    parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         opcode,
    input  logic [ffba_pkg::FIELD_W-1:0] req_size,
    input  logic [ffba_pkg::FIELD_W-1:0] payload_offset,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [1:0]                   status,
    output logic [ffba_pkg::FIELD_W-1:0] granted_offset
);
    import ffba_pkg::*;

    localparam int SW = $clog2(ARENA_BYTES + 1);
    localparam int XW = $clog2(ARENA_BYTES + 8192 + 2 * HEADER_BYTES + 1);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef struct packed {
        logic [SW-1:0] size;
        logic          free;
    } entry_t;

    typedef enum logic [12:0] {
        S_INIT = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_WEV  = 13'b0000000000100,
        S_MRD  = 13'b0000000001000,
        S_MWR  = 13'b0000000010000,
        S_SPL1 = 13'b0000000100000,
        S_SPL2 = 13'b0000001000000,
        S_CRD  = 13'b0000010000000,
        S_CEV  = 13'b0000100000000,
        S_CNX  = 13'b0001000000000,
        S_CWR  = 13'b0010000000000,
        S_DONE = 13'b0100000000000,
        S_SPR  = 13'b1000000000000
    } state_t;

    entry_t mem [MAX_BLOCKS];
    entry_t rdata;
    logic   mem_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    entry_t wdata;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] p_reg, p_next;
    logic [XW-1:0] start_reg, start_next;
    logic op_reg, op_next;
    logic [FIELD_W-1:0] req_reg, req_next;
    logic [FIELD_W-1:0] off_reg, off_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic dir_reg, dir_next;
    logic two_reg, two_next;
    entry_t prev_reg, prev_next;
    logic [1:0] res_st_reg, res_st_next;
    logic [FIELD_W-1:0] res_gnt_reg, res_gnt_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic [1:0] rsp_st_reg, rsp_st_next;
    logic [FIELD_W-1:0] rsp_gnt_reg, rsp_gnt_next;

    logic [XW-1:0] e_size;
    logic [XW-1:0] hdr;
    logic [CW:0]   idx_inc;
    logic [CW:0]   src_ptr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    assign e_size  = XW'(rdata.size);
    assign hdr     = XW'(HEADER_BYTES);
    assign idx_inc = {1'b0, idx_reg} + (CW+1)'(1);
    assign src_ptr = dir_reg ? ({1'b0, j_reg} - (CW+1)'(1))
                             : ({1'b0, j_reg} + (two_reg ? (CW+1)'(2) : (CW+1)'(1)));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        start_next     = start_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        dir_next       = dir_reg;
        two_next       = two_reg;
        prev_next      = prev_reg;
        res_st_next    = res_st_reg;
        res_gnt_next   = res_gnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_st_next    = rsp_st_reg;
        rsp_gnt_next   = rsp_gnt_reg;
        mem_we         = 1'b0;
        waddr          = idx_reg[AW-1:0];
        wdata          = rdata;
        raddr          = idx_reg[AW-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                waddr      = '0;
                wdata.size = SW'(ARENA_BYTES - HEADER_BYTES);
                wdata.free = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = opcode;
                    req_next     = req_size;
                    off_next     = payload_offset;
                    idx_next     = '0;
                    start_next   = '0;
                    raddr        = '0;
                    res_gnt_next = '0;
                    if (opcode == OP_ALLOC && req_size == '0)
                    begin
                        res_st_next = ST_NOMEM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WEV;
                    end
                end
            end
            S_WEV:
            begin
                if (op_reg == OP_ALLOC && rdata.free && e_size >= XW'(req_reg))
                begin
                    if (e_size == XW'(req_reg))
                    begin
                        mem_we       = 1'b1;
                        wdata.free   = 1'b0;
                        res_st_next  = ST_OK;
                        res_gnt_next = FIELD_W'(start_reg + hdr);
                        state_next   = S_DONE;
                    end
                    else if (e_size > XW'(req_reg) + hdr && count_reg < CW'(MAX_BLOCKS))
                    begin
                        rem_next     = SW'(e_size - XW'(req_reg) - hdr);
                        j_next       = count_reg;
                        dir_next     = 1'b1;
                        res_st_next  = ST_OK;
                        res_gnt_next = FIELD_W'(start_reg + hdr);
                        state_next   = S_MRD;
                    end
                    else
                    begin
                        res_st_next = ST_NOMEM;
                        state_next  = S_DONE;
                    end
                end
                else if (op_reg == OP_FREE && start_reg + hdr == XW'(off_reg))
                begin
                    mem_we      = 1'b1;
                    wdata.free  = 1'b1;
                    res_st_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_CRD;
                end
                else if (idx_inc >= {1'b0, count_reg})
                begin
                    res_st_next = (op_reg == OP_ALLOC) ? ST_NOMEM : ST_UNKNOWN;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc[CW-1:0];
                    start_next = start_reg + e_size + hdr;
                    raddr      = idx_inc[AW-1:0];
                end
            end
            S_MRD:
            begin
                raddr = src_ptr[AW-1:0];
                if (dir_reg)
                begin
                    state_next = ({1'b0, j_reg} > idx_inc) ? S_MWR : S_SPL1;
                end
                else if (src_ptr < {1'b0, count_reg})
                begin
                    state_next = S_MWR;
                end
                else
                begin
                    count_next = count_reg - (two_reg ? CW'(2) : CW'(1));
                    state_next = S_DONE;
                end
            end
            S_MWR:
            begin
                mem_we     = 1'b1;
                waddr      = j_reg[AW-1:0];
                j_next     = dir_reg ? j_reg - CW'(1) : j_reg + CW'(1);
                state_next = S_MRD;
            end
            S_SPL1:
            begin
                mem_we     = 1'b1;
                wdata.size = SW'(req_reg);
                wdata.free = 1'b0;
                state_next = S_SPL2;
            end
            S_SPL2:
            begin
                mem_we     = 1'b1;
                waddr      = idx_inc[AW-1:0];
                wdata.size = rem_reg;
                wdata.free = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_SPR;
            end
            S_SPR:
            begin
                state_next = S_DONE;
            end
            S_CRD:
            begin
                state_next = S_CEV;
            end
            S_CEV:
            begin
                if (idx_reg != '0 && prev_reg.free && rdata.free)
                begin
                    p_next   = idx_reg - CW'(1);
                    sum_next = SW'(XW'(prev_reg.size) + e_size + hdr);
                    if (idx_inc < {1'b0, count_reg})
                    begin
                        raddr      = idx_inc[AW-1:0];
                        state_next = S_CNX;
                    end
                    else
                    begin
                        two_next   = 1'b0;
                        state_next = S_CWR;
                    end
                end
                else
                begin
                    prev_next = rdata;
                    if (idx_inc >= {1'b0, count_reg})
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_inc[CW-1:0];
                        raddr    = idx_inc[AW-1:0];
                    end
                end
            end
            S_CNX:
            begin
                two_next = rdata.free;
                if (rdata.free)
                begin
                    sum_next = SW'(XW'(sum_reg) + e_size + hdr);
                end
                state_next = S_CWR;
            end
            S_CWR:
            begin
                mem_we     = 1'b1;
                waddr      = p_reg[AW-1:0];
                wdata.size = sum_reg;
                wdata.free = 1'b1;
                j_next     = p_reg + CW'(1);
                dir_next   = 1'b0;
                state_next = S_MRD;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_st_next    = res_st_reg;
                    rsp_gnt_next   = (res_st_reg == ST_OK) ? res_gnt_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= CW'(1);
            idx_reg       <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            start_reg     <= '0;
            op_reg        <= 1'b0;
            req_reg       <= '0;
            off_reg       <= '0;
            rem_reg       <= '0;
            sum_reg       <= '0;
            dir_reg       <= 1'b0;
            two_reg       <= 1'b0;
            prev_reg      <= '0;
            res_st_reg    <= ST_OK;
            res_gnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_st_reg    <= ST_OK;
            rsp_gnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            j_reg         <= j_next;
            p_reg         <= p_next;
            start_reg     <= start_next;
            op_reg        <= op_next;
            req_reg       <= req_next;
            off_reg       <= off_next;
            rem_reg       <= rem_next;
            sum_reg       <= sum_next;
            dir_reg       <= dir_next;
            two_reg       <= two_next;
            prev_reg      <= prev_next;
            res_st_reg    <= res_st_next;
            res_gnt_reg   <= res_gnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_st_reg    <= rsp_st_next;
            rsp_gnt_reg   <= rsp_gnt_next;
        end
    end

    assign req_ready      = (state_reg == S_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_st_reg;
    assign granted_offset = rsp_gnt_reg;

endmodule

// File: hw/rtl/ffba_checker.sv
// ---------------------------------------------------------------------------
// First-fit allocator port checker
// Port-level checks, bound to the allocator core.
// ---------------------------------------------------------------------------
`include "first_fit_block_allocator_core_macros.svh"

module ffba_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [1:0]                   status,
    input logic [ffba_pkg::FIELD_W-1:0] granted_offset
);
    import ffba_pkg::*;

    `FFBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `FFBA_ASSERT_NOW(a_fail_zero, rsp_valid && status != ST_OK, granted_offset == '0)
    `FFBA_ASSERT_NOW(a_status_code, rsp_valid, status <= ST_UNKNOWN)
    `FFBA_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);
